// File: hdl/kpu_pkg.sv
// kpu_pkg: types, constants and tables for the k-permutation unranker.
// No dependencies.
`default_nettype none
package kpu_pkg;

  localparam int NMax = 12;
  localparam int IdxW = 4;

  localparam logic [1:0] StElem     = 2'd0;
  localparam logic [1:0] StEmpty    = 2'd1;
  localparam logic [1:0] StRange    = 2'd2;
  localparam logic [1:0] StTooMany  = 2'd3;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  localparam logic [1:0] RegSetSize = 2'd0;
  localparam logic [1:0] RegChoose  = 2'd1;
  localparam logic [1:0] RegOrdered = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic [28:0]        rank;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] tuple_value;
    logic [3:0]         tuple_position;
    logic               last;
    logic [1:0]         status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_DIV, S_CSTEP, S_CREAD, S_CWRITE,
    S_PSTEP, S_PREAD, S_SHIFT_RD, S_SHIFT_WR, S_EMIT, S_REPORT
  } state_t;

  // constant table lookups; the tables fold to constants
  function automatic logic [28:0] fact(input logic [3:0] m);
    logic [28:0] t [0:NMax];
    t[0] = 29'd1;
    for (int i = 1; i <= NMax; i++) t[i] = t[i-1] * 29'(i);
    if (m > 4'(NMax)) return 29'd0;
    return t[m];
  endfunction

  // m! / (m-r)!
  function automatic logic [28:0] falling(input logic [3:0] m, input logic [3:0] r);
    logic [28:0] t [0:NMax][0:NMax];
    for (int a = 0; a <= NMax; a++)
      for (int b = 0; b <= NMax; b++)
        if (b == 0) t[a][b] = 29'd1;
        else if (a == 0) t[a][b] = 29'd0;
        else t[a][b] = t[a-1][b-1] * 29'(a);
    if (m > 4'(NMax) || r > 4'(NMax)) return 29'd0;
    return t[m][r];
  endfunction

  function automatic logic [28:0] binom(input logic [3:0] m, input logic [3:0] r);
    logic [28:0] t [0:12][0:12];
    for (int a = 0; a <= 12; a++)
      for (int b = 0; b <= 12; b++)
        if (b == 0) t[a][b] = 29'd1;
        else if (a == 0) t[a][b] = 29'd0;
        else t[a][b] = t[a-1][b-1] + t[a-1][b];
    if (m > 4'd12 || r > 4'd12) return 29'd0;
    return t[m][r];
  endfunction

endpackage
`default_nettype wire

// File: hdl/kpu_ram.sv
// kpu_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module kpu_ram #(
  parameter int Width = 32,
  parameter int Depth = 12
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/k_permutation_unranker.sv
// k_permutation_unranker: top level, store and sequencer for the unranker.
// Uses kpu_pkg and kpu_ram.
//
// channel | dir | handshake       | word
// in      | in  | in_valid/stall  | in_word_t
// out     | out | out_valid/stall | out_word_t
// cfg     | in  | APB             | set_size, choose_count, ordered_mode
// A query runs a check state, a restoring divide of the rank by k! (by 1 when
// unordered), the combination walk and, per output word, a digit search, a pool
// read, the emit and a pool shift. Error and empty-tuple queries go from the check
// state straight to a report.
// Reset clears store via valid bits; state machine returns to idle.
// A stalled output holds; no new item is taken until the query is done.
`default_nettype none
module k_permutation_unranker (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire kpu_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output kpu_pkg::out_word_t     out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [3:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);
  import kpu_pkg::*;

  logic [3:0] set_size, choose_count;
  logic       ordered_mode;
  logic [NMax-1:0] store_vld;

  state_t state, state_next;
  logic [3:0]  n, k, n_next, k_next;
  logic [28:0] rank, rank_next;      // remainder / prank during walk
  logic [28:0] quo, quo_next;
  logic [28:0] divisor, divisor_next;
  logic [4:0]  cnt, cnt_next;
  logic [3:0]  j, j_next, t, t_next, m, m_next, q, q_next, gi, gi_next;
  logic [28:0] s, s_next;
  logic [1:0]  rstat, rstat_next;
  logic        ord, ord_next;
  logic        busy_out;
  out_word_t   obuf;

  // element store
  logic        e_we;
  logic [3:0]  e_waddr, e_raddr;
  logic [31:0] e_rdata;
  logic [3:0]  e_raddr_q;
  // chosen values / pool
  logic        c_we;
  logic [3:0]  c_waddr, c_raddr;
  logic [31:0] c_wdata, c_rdata;
  logic [31:0] hold, hold_next;

  kpu_ram #(.Width(32), .Depth(NMax)) u_store (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(in_data.element_value),
    .raddr(e_raddr), .rdata(e_rdata));
  kpu_ram #(.Width(32), .Depth(NMax)) u_pool (
    .clk, .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .raddr(c_raddr), .rdata(c_rdata));

  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      RegSetSize: prdata = {28'd0, set_size};
      RegChoose:  prdata = {28'd0, choose_count};
      RegOrdered: prdata = {31'd0, ordered_mode};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_size <= 4'd0;
      choose_count <= 4'd0;
      ordered_mode <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegSetSize: set_size <= pwdata[3:0];
        RegChoose:  choose_count <= pwdata[3:0];
        RegOrdered: ordered_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  logic in_acc;
  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || out_valid;
  assign e_we = in_acc && in_data.operation == OpLoad && in_data.element_index < 4'(NMax);
  assign e_waddr = in_data.element_index;

  always_ff @(posedge clk) begin
    if (rst) store_vld <= '0;
    else if (e_we) store_vld[e_waddr] <= 1'b1;
  end

  logic [29:0] dtry;
  logic [28:0] bnt, fk, tot;
  assign bnt = binom(n - t, k - j);
  assign fk  = fact(k - j);
  assign tot = ord ? falling(n, k) : binom(n, k);

  always_comb begin
    state_next = state;
    n_next = n; k_next = k; rank_next = rank; quo_next = quo;
    divisor_next = divisor; cnt_next = cnt; j_next = j; t_next = t;
    m_next = m; q_next = q; gi_next = gi; s_next = s;
    rstat_next = rstat; ord_next = ord; hold_next = hold;
    e_raddr = 4'd0; c_we = 1'b0; c_waddr = 4'd0; c_wdata = e_rdata; c_raddr = 4'd0;
    dtry = {rank[28:0], quo[28]} - {1'b0, divisor};
    busy_out = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_acc && in_data.operation == OpQuery) begin
          n_next = (set_size > 4'(NMax)) ? 4'(NMax) : set_size;
          k_next = choose_count;
          ord_next = ordered_mode;
          quo_next = in_data.rank;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (k > n) begin rstat_next = StTooMany; state_next = S_REPORT; end
        else if (quo >= tot) begin rstat_next = StRange; state_next = S_REPORT; end
        else if (k == 4'd0) begin rstat_next = StEmpty; state_next = S_REPORT; end
        else begin
          divisor_next = ord ? fact(k) : 29'd1;
          rank_next = 29'd0; cnt_next = 5'd0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division: quo becomes crank, rank becomes prank
        if (!dtry[29]) begin
          rank_next = dtry[28:0];
          quo_next = {quo[27:0], 1'b1};
        end else begin
          rank_next = {rank[27:0], quo[28]};
          quo_next = {quo[27:0], 1'b0};
        end
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd28) begin
          j_next = 4'd1; t_next = 4'd1; s_next = 29'd0;
          state_next = S_CSTEP;
        end
      end
      S_CSTEP: begin
        if (t < n - k + j && s + bnt <= quo) begin
          s_next = s + bnt;
          t_next = t + 4'd1;
        end else begin
          e_raddr = t - 4'd1;
          state_next = S_CREAD;
        end
      end
      S_CREAD: begin
        c_we = 1'b1; c_waddr = j - 4'd1;
        c_wdata = store_vld[e_raddr_q] ? e_rdata : 32'd0;
        if (j == k) begin
          j_next = 4'd1; m_next = k; gi_next = 4'd0;
          state_next = S_PSTEP;
        end else begin
          j_next = j + 4'd1; t_next = t + 4'd1;
          state_next = S_CSTEP;
        end
      end
      S_PSTEP: begin
        // digit by repeated subtraction of (k-j)!, capped at m-1
        if (rank >= fk && gi < m - 4'd1) begin
          rank_next = rank - fk;
          gi_next = gi + 4'd1;
        end else begin
          c_raddr = gi;
          state_next = S_PREAD;
        end
      end
      S_PREAD: begin
        hold_next = c_rdata;
        q_next = gi;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        busy_out = 1'b1;
        if (j == k) state_next = S_IDLE;
        else begin
          c_raddr = q + 4'd1;
          state_next = (q + 4'd1 < m) ? S_SHIFT_RD : S_CWRITE;
        end
      end
      S_SHIFT_RD: begin
        c_we = 1'b1; c_waddr = q; c_wdata = c_rdata;
        q_next = q + 4'd1;
        c_raddr = q + 4'd2;
        if (q + 4'd2 >= m) state_next = S_CWRITE;
      end
      S_CWRITE: begin
        m_next = m - 4'd1; j_next = j + 4'd1; gi_next = 4'd0;
        state_next = S_PSTEP;
      end
      S_REPORT: begin
        busy_out = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if ((state == S_EMIT || state == S_REPORT) && out_valid) begin
      state_next = state; busy_out = 1'b0;
      c_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
    n <= n_next; k <= k_next; rank <= rank_next; quo <= quo_next;
    divisor <= divisor_next; cnt <= cnt_next; j <= j_next; t <= t_next;
    m <= m_next; q <= q_next; gi <= gi_next; s <= s_next;
    rstat <= rstat_next; ord <= ord_next; hold <= hold_next;
    e_raddr_q <= e_raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (busy_out) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (busy_out) begin
      if (state == S_REPORT) obuf <= '{tuple_value: 32'sd0, tuple_position: 4'd0,
                                        last: 1'b1, status: rstat};
      else obuf <= '{tuple_value: hold, tuple_position: j - 4'd1,
                     last: (j == k), status: StElem};
    end
  end
  assign out_data = obuf;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> in_stall) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("output dropped");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt <= 5'd28) else $error("divider overran");
endmodule
`default_nettype wire

// File: sim/k_permutation_unranker_tb.sv
// Self-checking testbench for k_permutation_unranker: loads the element store, programs
// n, k and mode over APB, and checks every tuple word against a behavioral unranker.
// Depends on kpu_pkg and the k_permutation_unranker RTL.

class tuple_scoreboard;
  logic signed [31:0] store_vals [12];
  int unsigned n_sel, k_sel;
  bit ord_mode;
  kpu_pkg::out_word_t pending [$];
  int errors;

  function new();
    foreach (store_vals[i]) store_vals[i] = '0;
    n_sel = 0; k_sel = 0; ord_mode = 1; errors = 0;
  endfunction

  function longint unsigned factorial(int unsigned m);
    longint unsigned r;
    r = 1;
    for (int i = 2; i <= m; i++) r = r * i;
    return r;
  endfunction

  function longint unsigned choose(int unsigned m, int unsigned r);
    longint unsigned v;
    v = 1;
    if (r > m) return 0;
    for (int i = 0; i < r; i++) v = v * (m - i) / (i + 1);
    return v;
  endfunction

  function void push_word(logic signed [31:0] v, int unsigned pos, bit lst, logic [1:0] st);
    kpu_pkg::out_word_t w;
    w.tuple_value = v; w.tuple_position = pos[3:0]; w.last = lst; w.status = st;
    pending = {pending, w};
  endfunction

  function void note_input(kpu_pkg::in_word_t iw);
    int unsigned n, k, t, prev, m, gi;
    longint unsigned rnk, total, crank, prank, s, ind, f, g;
    logic signed [31:0] pool [12];
    if (iw.operation == kpu_pkg::OpLoad) begin
      if (iw.element_index < 12) store_vals[iw.element_index] = iw.element_value;
      return;
    end
    n = (n_sel > 12) ? 12 : n_sel;
    k = k_sel;
    rnk = iw.rank;
    if (k > n) begin
      push_word(0, 0, 1, kpu_pkg::StTooMany);
      return;
    end
    total = ord_mode ? factorial(n) / factorial(n - k) : choose(n, k);
    if (rnk >= total) begin
      push_word(0, 0, 1, kpu_pkg::StRange);
      return;
    end
    if (k == 0) begin
      push_word(0, 0, 1, kpu_pkg::StEmpty);
      return;
    end
    if (ord_mode) begin
      crank = rnk / factorial(k);
      prank = rnk % factorial(k);
    end else begin
      crank = rnk; prank = 0;
    end
    s = 0; prev = 0;
    for (int j = 1; j <= k; j++) begin
      t = prev + 1;
      while (t < n - k + j && s + choose(n - t, k - j) <= crank) begin
        s += choose(n - t, k - j);
        t++;
      end
      pool[j - 1] = store_vals[(t - 1) % 12];
      prev = t;
    end
    m = k; ind = prank + 1;
    for (int j = 1; j <= k; j++) begin
      f = factorial(k - j);
      g = (ind + f - 1) / f;
      if (g < 1) g = 1;
      if (g > m) g = m;
      gi = 32'(g - 1);
      push_word(pool[gi], j - 1, j == k, kpu_pkg::StElem);
      for (int q = gi; q + 1 < m; q++) pool[q] = pool[q + 1];
      m--;
      ind -= (g - 1) * f;
    end
  endfunction

  task check_result(kpu_pkg::out_word_t got);
    kpu_pkg::out_word_t exp_w;
    if (pending.size() == 0) begin
      report_err($sformatf("unexpected word %h", got));
      return;
    end
    exp_w = pending.pop_front();
    if (got.tuple_value !== exp_w.tuple_value)
      report_err($sformatf("tuple_value %0d exp %0d", got.tuple_value, exp_w.tuple_value));
    if (got.tuple_position !== exp_w.tuple_position)
      report_err($sformatf("tuple_position %0d exp %0d", got.tuple_position,
                           exp_w.tuple_position));
    if (got.last !== exp_w.last)
      report_err($sformatf("last %0b exp %0b", got.last, exp_w.last));
    if (got.status !== exp_w.status)
      report_err($sformatf("status %0d exp %0d", got.status, exp_w.status));
  endtask

  task report_err(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask
endclass

module k_permutation_unranker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  kpu_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  kpu_pkg::out_word_t out_data;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  tuple_scoreboard sb = new();
  bit hold_off = 0;

  always #6 clk = ~clk;

  k_permutation_unranker u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  // receiver: own stall pattern, plus long hold-off on request
  always @(posedge clk) begin
    if (out_valid && !out_stall && !rst) sb.check_result(out_data);
    if (hold_off) out_stall <= 1;
    else case ($urandom_range(0, 3))
      0: out_stall <= ($urandom_range(0, 1) == 0);
      1: out_stall <= ($urandom_range(0, 4) == 0);
      default: out_stall <= 0;
    endcase
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      kpu_pkg::RegSetSize: sb.n_sel = val[3:0];
      kpu_pkg::RegChoose:  sb.k_sel = val[3:0];
      default:             sb.ord_mode = val[0];
    endcase
  endtask

  int burst_left = 0;

  // valid stays high between words of a burst; gaps and drain drop it
  task automatic send_word(kpu_pkg::in_word_t w, bit no_gap = 0);
    if (!no_gap && burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_valid <= 1; in_data <= w;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic load(int idx, logic [31:0] v);
    kpu_pkg::in_word_t w;
    w = '0; w.operation = kpu_pkg::OpLoad; w.element_index = idx[3:0]; w.element_value = v;
    send_word(w);
  endtask

  task automatic query(logic [28:0] r);
    kpu_pkg::in_word_t w;
    w = '0; w.operation = kpu_pkg::OpQuery; w.rank = r;
    w.element_index = 4'($urandom); w.element_value = $urandom;
    send_word(w);
  endtask

  task automatic drain();
    in_valid <= 0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic setup(int n, int k, bit o);
    drain();
    reg_write(kpu_pkg::RegSetSize, n);
    reg_write(kpu_pkg::RegChoose, k);
    reg_write(kpu_pkg::RegOrdered, {31'd0, o});
  endtask

  function automatic logic [28:0] tuple_count();
    int unsigned n;
    n = sb.n_sel > 12 ? 12 : sb.n_sel;
    if (sb.k_sel > n) return 1;
    return 29'(sb.ord_mode ? sb.factorial(n) / sb.factorial(n - sb.k_sel)
                           : sb.choose(n, sb.k_sel));
  endfunction

  initial begin
    logic [28:0] cnt;
    int nn, kk;
    repeat (11) @(posedge clk);
    rst <= 0;
    // directed
    query(0);
    setup(12, 12, 1);
    for (int i = 0; i < 12; i++) load(i, i[0] ? 32'h8000_0000 + i : 32'h7fff_fff0 + i);
    load(15, 32'hdead_beef);
    load(12, 32'hffff_ffff);
    query(0); query(29'd479001599); query(29'd479001600); query(29'h1fff_ffff);
    setup(12, 0, 0);
    query(0); query(1);
    setup(3, 5, 1);
    query(0);
    setup(15, 4, 0);
    query(0); query(494); query(495);
    setup(12, 6, 1);
    query(29'd665279); query(12345);
    // random
    for (int ph = 0; ph < 12; ph++) begin
      nn = $urandom_range(0, 15); kk = $urandom_range(0, nn < 12 ? nn + 1 : 12);
      setup(nn, kk, $urandom_range(0, 1));
      cnt = tuple_count();
      if (ph == 5) fork
        begin hold_off = 1; repeat (400) @(posedge clk); hold_off = 0; end
      join_none
      for (int i = 0; i < 9; i++) begin
        if ($urandom_range(0, 3) == 0) load($urandom_range(0, 15), $urandom);
        else if ($urandom_range(0, 7) == 0) query(29'($urandom));
        else query(29'($urandom_range(0, cnt - 1)));
      end
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) $display("PASS k_permutation_unranker");
    else $display("FAIL k_permutation_unranker");
    $finish;
  end

  initial begin
    #(20ms);
    $display("FAIL k_permutation_unranker");
    $finish;
  end
endmodule
